// ===== rtl/m4rm_pkg.sv =====
// shared types and constants for the 4x4 row multiplier
`default_nettype none

package m4rm_pkg;

	// number of element fields on each port and their width
	localparam int NUM_ELEMS = 4;
	localparam int ELEM_W    = 32;

	// item function codes
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_MUL  = 1'b1
	} m4rm_func_t;

	// control that travels with each item down the cell chain
	typedef struct packed {
		logic       vld;
		m4rm_func_t func;
		logic [1:0] row;
	} m4rm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/m4rm_cell.sv =====
// one cell of the chain: holds one row of B and adds its products to the passing sums
`default_nettype none

module m4rm_cell
	import m4rm_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int CELL_ROW   = 0,
	parameter int NE         = 4,
	parameter int ACC_W      = 66
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                adv,
	input  m4rm_ctl_t                          ctl_in,
	input  wire  [NE-1:0][DATA_WIDTH-1:0]      row_in,
	input  wire  [NE-1:0][ACC_W-1:0]           acc_in,
	output m4rm_ctl_t                          ctl_out,
	output logic [NE-1:0][DATA_WIDTH-1:0]      row_out,
	output logic [NE-1:0][ACC_W-1:0]           acc_out
);

	localparam int         PROD_W   = 2 * DATA_WIDTH;
	localparam bit         LOADABLE = (CELL_ROW < 4);
	localparam logic [1:0] ROW_CODE = 2'(CELL_ROW % 4);

	logic [NE-1:0][DATA_WIDTH-1:0] b_q;
	logic signed [DATA_WIDTH-1:0]  a_elem;
	logic [NE-1:0][PROD_W-1:0]     prod_d;

	m4rm_ctl_t                     ctl_s1;
	logic [NE-1:0][DATA_WIDTH-1:0] row_s1;
	logic [NE-1:0][ACC_W-1:0]      acc_s1;
	logic [NE-1:0][PROD_W-1:0]     prod_s1;

	m4rm_ctl_t                     ctl_s2;
	logic [NE-1:0][DATA_WIDTH-1:0] row_s2;
	logic [NE-1:0][ACC_W-1:0]      acc_s2;

	logic load_hit;

	// element of the A row that meets this row of B
	if (CELL_ROW < NE) begin : g_a
		assign a_elem = $signed(row_in[CELL_ROW]);
	end else begin : g_zero
		assign a_elem = '0;
	end

	// a load row is written when it reaches this cell, so items keep their order
	assign load_hit = adv && ctl_in.vld && (ctl_in.func == FUNC_LOAD) && LOADABLE
		&& (ctl_in.row == ROW_CODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (load_hit) begin
			b_q <= row_in;
		end
	end

	// one product per output column
	always_comb begin
		for (int c = 0; c < NE; c++) begin
			prod_d[c] = PROD_W'(a_elem * $signed(b_q[c]));
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	// product stage, then accumulate stage
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1  <= row_in;
			acc_s1  <= acc_in;
			prod_s1 <= prod_d;
			row_s2  <= row_s1;
			for (int c = 0; c < NE; c++) begin
				acc_s2[c] <= acc_s1[c] + ACC_W'($signed(prod_s1[c]));
			end
		end
	end

	assign ctl_out = ctl_s2;
	assign row_out = row_s2;
	assign acc_out = acc_s2;

endmodule

`default_nettype wire

// ===== rtl/matrix4_row_multiply.sv =====
// top level: fixed-point row-at-a-time matrix multiply built from a chain of cells
`default_nettype none

// Computes one row of C = A x B per multiply item in signed fixed point with
// FRAC_BITS fraction bits (Q16.16 by default). A load item (func 0) writes row
// row_index of B and gives no result; a load whose row is not below DIM is
// dropped. A multiply item (func 1) gives one result row, each column the
// exact dot product shifted right by FRAC_BITS (toward minus infinity) and
// saturated, with saturated set if any column clipped. One item is taken
// every cycle while in_ready is high. A result passes 2*DIM+1 registers,
// a product stage and an accumulate stage in each of the DIM cells and
// then the truncation and saturation register; the first of them loads at
// the transfer edge itself. Loads travel the same chain, so a multiply
// always sees B as left by the items before it. When a result sits unread
// in the output register, in_ready drops and the whole chain holds. B
// resets to all zeros.
module matrix4_row_multiply
	import m4rm_pkg::*;
#(
	parameter int DIM        = 4,
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               func,
	input  wire  [1:0]        row_index,
	input  wire  [ELEM_W-1:0] elem0,
	input  wire  [ELEM_W-1:0] elem1,
	input  wire  [ELEM_W-1:0] elem2,
	input  wire  [ELEM_W-1:0] elem3,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [ELEM_W-1:0] out0,
	output logic [ELEM_W-1:0] out1,
	output logic [ELEM_W-1:0] out2,
	output logic [ELEM_W-1:0] out3,
	output logic              saturated
);

	localparam int NE    = (DIM < NUM_ELEMS) ? DIM : NUM_ELEMS;
	localparam int ACC_W = 2 * DATA_WIDTH + $clog2(DIM);
	localparam int DW    = DATA_WIDTH;

	localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

	logic                               adv;
	logic [NUM_ELEMS-1:0][ELEM_W-1:0]   elem_in;

	m4rm_ctl_t                          ctl_c [DIM+1];
	logic [NE-1:0][DW-1:0]              row_c [DIM+1];
	logic [NE-1:0][ACC_W-1:0]           acc_c [DIM+1];

	logic [NUM_ELEMS-1:0][ELEM_W-1:0]   res_d;
	logic                               sat_d;

	logic                               out_valid_q;
	logic [NUM_ELEMS-1:0][ELEM_W-1:0]   res_q;
	logic                               sat_q;

	// chain moves whenever the output register is free or being drained
	assign adv      = out_ready || !out_valid_q;
	assign in_ready = adv;

	// head of the chain
	assign elem_in      = {elem3, elem2, elem1, elem0};
	assign ctl_c[0].vld  = in_valid;
	assign ctl_c[0].func = m4rm_func_t'(func);
	assign ctl_c[0].row  = row_index;
	assign acc_c[0]      = '0;

	for (genvar k = 0; k < NE; k++) begin : g_row_in
		assign row_c[0][k] = elem_in[k][DW-1:0];
	end

	// one cell per row of B
	for (genvar i = 0; i < DIM; i++) begin : g_cell
		m4rm_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CELL_ROW  (i),
			.NE        (NE),
			.ACC_W     (ACC_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_in (ctl_c[i]),
			.row_in (row_c[i]),
			.acc_in (acc_c[i]),
			.ctl_out(ctl_c[i+1]),
			.row_out(row_c[i+1]),
			.acc_out(acc_c[i+1])
		);
	end

	// drop fraction bits and saturate each column
	always_comb begin
		logic signed [ACC_W-1:0] acc_v;
		logic signed [ACC_W-1:0] shr_v;
		logic [ACC_W-DW:0]       upper_v;
		logic [DW-1:0]           val_v;
		res_d = '0;
		sat_d = 1'b0;
		for (int c = 0; c < NE; c++) begin
			acc_v   = $signed(acc_c[DIM][c]);
			shr_v   = acc_v >>> FRAC_BITS;
			upper_v = shr_v[ACC_W-1:DW-1];
			if ((&upper_v) || !(|upper_v)) begin
				val_v = shr_v[DW-1:0];
			end else begin
				val_v = shr_v[ACC_W-1] ? SAT_MIN : SAT_MAX;
				sat_d = 1'b1;
			end
			res_d[c] = ELEM_W'($signed(val_v));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_c[DIM].vld && (ctl_c[DIM].func == FUNC_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
			sat_q <= sat_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out0      = res_q[0];
	assign out1      = res_q[1];
	assign out2      = res_q[2];
	assign out3      = res_q[3];
	assign saturated = sat_q;

endmodule

`default_nettype wire

// ===== rtl/m4rm_checker.sv =====
// port-level checks for the row multiplier and their binding
`default_nettype none

module m4rm_checker
	import m4rm_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              func,
	input wire [1:0]        row_index,
	input wire [ELEM_W-1:0] elem0,
	input wire [ELEM_W-1:0] elem1,
	input wire [ELEM_W-1:0] elem2,
	input wire [ELEM_W-1:0] elem3,
	input wire              out_valid,
	input wire              out_ready,
	input wire [ELEM_W-1:0] out0,
	input wire [ELEM_W-1:0] out1,
	input wire [ELEM_W-1:0] out2,
	input wire [ELEM_W-1:0] out3,
	input wire              saturated
);

	localparam logic [ELEM_W-1:0] SAT_MAX = ELEM_W'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
	localparam logic [ELEM_W-1:0] SAT_MIN = ~SAT_MAX;

	logic out_stall;
	logic in_stall;
	assign out_stall = out_valid && !out_ready;
	assign in_stall  = in_valid && !in_ready;

	// a waiting input transfer stays offered with the same payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (in_valid && $stable(func) && $stable(row_index) && $stable(elem0)
			&& $stable(elem1) && $stable(elem2) && $stable(elem3)))
		else $error("input transfer withdrawn or changed while waiting");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> ($stable(out0) && $stable(out1) && $stable(out2) && $stable(out3)
			&& $stable(saturated)))
		else $error("result changed while stalled");

	// a full, unread output register blocks input transfers
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |-> !in_ready)
		else $error("input taken while output stalled");

	// a clipped row shows at least one column at a limit
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (out0 == SAT_MAX || out0 == SAT_MIN
			|| out1 == SAT_MAX || out1 == SAT_MIN || out2 == SAT_MAX || out2 == SAT_MIN
			|| out3 == SAT_MAX || out3 == SAT_MIN))
		else $error("saturated flag without a clipped column");

endmodule

bind matrix4_row_multiply m4rm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_m4rm_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the fixed-point 4x4 row multiplier
module tb_top;
	import m4rm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM        = 4;
	localparam int FRAC_BITS  = 16;
	localparam int LATENCY    = 2 * DIM + 1;
	localparam int MAX_CYCLES = 200000;
	localparam int HOLD_LEN   = 400;

	localparam logic signed [127:0] Q_MAX = 128'sh7fffffff;
	localparam logic signed [127:0] Q_MIN = -128'sh80000000;

	typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] elem_row_t;

	typedef struct packed {
		elem_row_t c;
		logic      sat;
	} row_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	m4rm_func_t        in_func   = FUNC_LOAD;
	logic [1:0]        in_row    = 2'd0;
	elem_row_t         in_elems  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ELEM_W-1:0] out0, out1, out2, out3;
	logic              saturated;

	// copy of the stored B matrix, updated at each accepted load
	logic [ELEM_W-1:0] b_model [DIM*DIM];
	row_result_t       expected_rows [$];

	int errors        = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_ack      = 0;
	int hold_left     = 0;

	matrix4_row_multiply u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (in_func),
		.row_index (in_row),
		.elem0     (in_elems[0]),
		.elem1     (in_elems[1]),
		.elem2     (in_elems[2]),
		.elem3     (in_elems[3]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out0      (out0),
		.out1      (out1),
		.out2      (out2),
		.out3      (out3),
		.saturated (saturated)
	);

	always #4 clk = ~clk;

	// dot products of an A row with the columns of B, truncated and clipped
	function automatic row_result_t predict_row(input elem_row_t a);
		row_result_t        res;
		logic signed [63:0]  ea, eb;
		logic signed [127:0] acc;
		res = '0;
		for (int col = 0; col < NUM_ELEMS; col++) begin
			acc = '0;
			for (int k = 0; k < DIM; k++) begin
				ea = $signed(a[k]);
				eb = $signed(b_model[k*DIM + col]);
				acc = acc + ea * eb;
			end
			acc = acc >>> FRAC_BITS;
			if (acc > Q_MAX) begin
				res.c[col] = 32'h7fffffff;
				res.sat = 1'b1;
			end else if (acc < Q_MIN) begin
				res.c[col] = 32'h80000000;
				res.sat = 1'b1;
			end else begin
				res.c[col] = acc[ELEM_W-1:0];
			end
		end
		return res;
	endfunction

	// random element: full range, small or moderate Q16.16, or an extreme
	function automatic logic [ELEM_W-1:0] rand_elem(input int style);
		int v;
		case (style)
			0: v = $urandom();
			1: v = int'($urandom_range(1048576)) - 524288;
			2: begin
				v = int'($urandom_range(32'h00ffffff));
				if ($urandom_range(1)) v = -v;
			end
			default: begin
				case ($urandom_range(4))
					0: v = 32'h7fffffff;
					1: v = 32'h80000000;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
		endcase
		return v;
	endfunction

	// one input transfer; valid stays high between back-to-back items
	task automatic send_row(input m4rm_func_t f, input logic [1:0] r, input elem_row_t e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_func  <= f;
		in_row   <= r;
		in_elems <= e;
		do @(posedge clk); while (!in_ready);
		if (f == FUNC_LOAD) begin
			for (int k = 0; k < DIM; k++) b_model[r*DIM + k] = e[k];
		end else begin
			expected_rows.push_back(predict_row(e));
		end
	endtask

	// sender drops valid and waits for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
	endtask

	task automatic random_row(output m4rm_func_t f, output logic [1:0] r, output elem_row_t e);
		int style;
		style = $urandom_range(3);
		f = ($urandom_range(99) < 35) ? FUNC_LOAD : FUNC_MUL;
		r = 2'($urandom_range(3));
		for (int k = 0; k < NUM_ELEMS; k++)
			e[k] = ($urandom_range(9) == 0) ? rand_elem($urandom_range(3)) : rand_elem(style);
	endtask

	// extremes, identity pass-through, truncation toward minus infinity, clipping
	task automatic test_directed();
		elem_row_t e;
		send_row(FUNC_MUL, 2'd0, {32'h7fffffff, 32'hfffd0000, 32'h00020000, 32'h00010000});
		for (int r = 0; r < DIM; r++) begin
			e = '0;
			e[r] = 32'h00010000;
			send_row(FUNC_LOAD, r[1:0], e);
		end
		send_row(FUNC_MUL, 2'd2, {32'hffffffff, 32'h00000001, 32'h80000000, 32'h7fffffff});
		send_row(FUNC_MUL, 2'd3, '0);
		send_row(FUNC_LOAD, 2'd0, {32'h00000000, 32'h00010000, 32'hffff8000, 32'h00008000});
		send_row(FUNC_MUL, 2'd1, {32'h0, 32'h0, 32'h0, 32'hffffffff});
		send_row(FUNC_MUL, 2'd0, {32'h0, 32'h0, 32'h0, 32'h00000001});
		for (int r = 0; r < DIM; r++)
			send_row(FUNC_LOAD, r[1:0], {4{32'h7fffffff}});
		send_row(FUNC_MUL, 2'd0, {4{32'h7fffffff}});
		send_row(FUNC_MUL, 2'd0, {4{32'h80000000}});
		send_row(FUNC_MUL, 2'd0, {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
		send_row(FUNC_LOAD, 2'd1, {4{32'h80000000}});
		send_row(FUNC_MUL, 2'd3, {32'h0, 32'h0, 32'h80000000, 32'h0});
		wait_drained();
	endtask

	task automatic test_random_mix(input int n, input int sidle, input int ridle);
		m4rm_func_t f;
		logic [1:0] r;
		elem_row_t  e;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int i = 0; i < n; i++) begin
			random_row(f, r, e);
			send_row(f, r, e);
		end
		wait_drained();
	endtask

	// receiver holds off long enough for the chain to fill and stall the input
	task automatic test_output_stall();
		m4rm_func_t f;
		logic [1:0] r;
		elem_row_t  e;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_req = hold_req + 1;
		for (int i = 0; i < 40; i++) begin
			random_row(f, r, e);
			send_row(FUNC_MUL, r, e);
		end
		wait_drained();
	endtask

	// sender stops mid-stream until all results are back, then resumes
	task automatic test_sender_pause();
		m4rm_func_t f;
		logic [1:0] r;
		elem_row_t  e;
		send_idle_pct = 10;
		recv_idle_pct = 30;
		for (int i = 0; i < 20; i++) begin
			random_row(f, r, e);
			send_row(f, r, e);
			if (i == 9) wait_drained();
		end
		wait_drained();
	endtask

	// receiver ready: long hold on request, else random idling
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_LEN - 1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result transfer with the oldest expected row
	always @(posedge clk) begin : check_blk
		row_result_t want;
		elem_row_t   got;
		if (arst_n && out_valid && out_ready) begin
			got = {out3, out2, out1, out0};
			if (expected_rows.size() == 0) begin
				$display("%0t: result with nothing expected: %h %h %h %h sat %b",
					$time, out0, out1, out2, out3, saturated);
				errors = errors + 1;
			end else begin
				want = expected_rows.pop_front();
				for (int i = 0; i < NUM_ELEMS; i++) begin
					if (got[i] !== want.c[i]) begin
						$display("%0t: out%0d expected %h actual %h",
							$time, i, want.c[i], got[i]);
						errors = errors + 1;
					end
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %b actual %b",
						$time, want.sat, saturated);
					errors = errors + 1;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("matrix4_row_multiply regression: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DIM*DIM; i++) b_model[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_mix(150, 14, 82);
		test_random_mix(150, 82, 14);
		test_output_stall();
		test_sender_pause();
		test_random_mix(70, 0, 0);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("matrix4_row_multiply regression: pass");
		end else begin
			$display("matrix4_row_multiply regression: fail");
		end
		$finish;
	end

endmodule
